### rtl/core/rvd_pkg.sv
// Shared types and mnemonic codes for the RV32IM instruction decoder.
`timescale 1ns / 1ps

package rvd_pkg;

    // Mnemonic codes, in the order the decoder reports them.
    localparam logic [5:0] MN_NONE   = 6'd0;
    localparam logic [5:0] MN_MUL    = 6'd1;
    localparam logic [5:0] MN_MULH   = 6'd2;
    localparam logic [5:0] MN_MULHSU = 6'd3;
    localparam logic [5:0] MN_MULHU  = 6'd4;
    localparam logic [5:0] MN_DIV    = 6'd5;
    localparam logic [5:0] MN_DIVU   = 6'd6;
    localparam logic [5:0] MN_REM    = 6'd7;
    localparam logic [5:0] MN_REMU   = 6'd8;
    localparam logic [5:0] MN_ADD    = 6'd9;
    localparam logic [5:0] MN_SUB    = 6'd10;
    localparam logic [5:0] MN_XOR    = 6'd11;
    localparam logic [5:0] MN_OR     = 6'd12;
    localparam logic [5:0] MN_AND    = 6'd13;
    localparam logic [5:0] MN_SLL    = 6'd14;
    localparam logic [5:0] MN_SRL    = 6'd15;
    localparam logic [5:0] MN_SRA    = 6'd16;
    localparam logic [5:0] MN_SLT    = 6'd17;
    localparam logic [5:0] MN_SLTU   = 6'd18;
    localparam logic [5:0] MN_ADDI   = 6'd19;
    localparam logic [5:0] MN_XORI   = 6'd20;
    localparam logic [5:0] MN_ORI    = 6'd21;
    localparam logic [5:0] MN_ANDI   = 6'd22;
    localparam logic [5:0] MN_SLLI   = 6'd23;
    localparam logic [5:0] MN_SRAI   = 6'd24;
    localparam logic [5:0] MN_SRLI   = 6'd25;
    localparam logic [5:0] MN_SLTI   = 6'd26;
    localparam logic [5:0] MN_SLTIU  = 6'd27;
    localparam logic [5:0] MN_LB     = 6'd28;
    localparam logic [5:0] MN_LH     = 6'd29;
    localparam logic [5:0] MN_LW     = 6'd30;
    localparam logic [5:0] MN_LBU    = 6'd31;
    localparam logic [5:0] MN_LHU    = 6'd32;
    localparam logic [5:0] MN_SB     = 6'd33;
    localparam logic [5:0] MN_SH     = 6'd34;
    localparam logic [5:0] MN_SW     = 6'd35;
    localparam logic [5:0] MN_BEQ    = 6'd36;
    localparam logic [5:0] MN_BNE    = 6'd37;
    localparam logic [5:0] MN_BLT    = 6'd38;
    localparam logic [5:0] MN_BGE    = 6'd39;
    localparam logic [5:0] MN_BLTU   = 6'd40;
    localparam logic [5:0] MN_BGEU   = 6'd41;
    localparam logic [5:0] MN_JAL    = 6'd42;
    localparam logic [5:0] MN_JALR   = 6'd43;
    localparam logic [5:0] MN_LUI    = 6'd44;
    localparam logic [5:0] MN_AUIPC  = 6'd45;
    localparam logic [5:0] MN_ECALL  = 6'd46;
    localparam logic [5:0] MN_EBREAK = 6'd47;

    // Decoded fields handed from the decode logic to the result register.
    typedef struct packed {
        logic               recognized;
        logic [5:0]         code;
        logic signed [31:0] immediate;
        logic [31:0]        target;
    } decode_result_t;

endpackage

### rtl/core/rv32im_instruction_decoder.sv
// Top level of the RV32IM instruction decoder: input stage, decode, result register.
//
//  Channel  Ports            Direction  Moves
//  s_       valid/ready      in         one 32-bit instruction word per transfer
//  m_       valid/ready      out        one decoded result per transfer
//  cfg_     valid/ready      in         start address; restarts the word counter
//
// Each word passes through the input register and then the result register, and a
// stall on m_ready can hold it in either; one word per cycle is sustained while
// m_ready stays high.
// The pc is formed at input transfer from the start address and the word counter.
// aresetn is synchronous, active low; it clears the valid flags, start address and counter.
// A stall on m_ready holds the result register and back-pressures the input register.
`timescale 1ns / 1ps

module rv32im_instruction_decoder
    import rvd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_instruction,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_item_pc,
    output logic               m_recognized,
    output logic [5:0]         m_mnemonic_code,
    output logic [4:0]         m_dest_reg,
    output logic [4:0]         m_src1_reg,
    output logic [4:0]         m_src2_reg,
    output logic signed [31:0] m_immediate,
    output logic [31:0]        m_target
);

    logic           in_valid_reg;
    logic [31:0]    in_instr_reg;
    logic [31:0]    in_pc_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [31:0]    out_pc_reg;
    logic [14:0]    out_regs_reg;
    decode_result_t out_result_reg;
    logic           in_take;
    logic           out_load;
    logic [31:0]    accept_pc;
    decode_result_t dec_result;

    // Handshake control between the two register stages.
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_take  = s_valid && s_ready;

    rvd_pc_counter u_pc_counter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (in_take),
        .pc        (accept_pc)
    );

    // Input register: instruction word and its pc.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_take) begin
            in_instr_reg <= s_instruction;
            in_pc_reg    <= accept_pc;
        end
    end

    rvd_decode u_decode (
        .instruction (in_instr_reg),
        .pc          (in_pc_reg),
        .result      (dec_result)
    );

    // Result register valid: set on load, cleared when the result is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (out_load) begin
            out_pc_reg     <= in_pc_reg;
            out_regs_reg   <= {in_instr_reg[11:7], in_instr_reg[19:15], in_instr_reg[24:20]};
            out_result_reg <= dec_result;
        end
    end

    // Result ports.
    assign m_valid         = out_valid_reg;
    assign m_item_pc       = out_pc_reg;
    assign m_recognized    = out_result_reg.recognized;
    assign m_mnemonic_code = out_result_reg.code;
    assign m_dest_reg      = out_regs_reg[14:10];
    assign m_src1_reg      = out_regs_reg[9:5];
    assign m_src2_reg      = out_regs_reg[4:0];
    assign m_immediate     = out_result_reg.immediate;
    assign m_target        = out_result_reg.target;

endmodule

### rtl/core/rvd_pc_counter.sv
// Start address register and word counter that produce the pc of each word.
`timescale 1ns / 1ps

module rvd_pc_counter
    import rvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        advance,
    output logic [31:0] pc
);

    logic [31:0] start_pc_reg;
    logic [29:0] counter_reg;

    // Configuration is always taken; the user, not the block, keeps it to idle.
    assign cfg_ready = 1'b1;

    // A configuration transfer restarts the count; each accepted word advances it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= 32'd0;
            counter_reg  <= 30'd0;
        end else if (cfg_valid) begin
            start_pc_reg <= cfg_data;
            counter_reg  <= 30'd0;
        end else if (advance) begin
            counter_reg  <= counter_reg + 30'd1;
        end
    end

    // Address of the word being accepted now.
    assign pc = start_pc_reg + {counter_reg, 2'b00};

endmodule

### rtl/core/rvd_decode.sv
// Combinational RV32IM decode: mnemonic, immediate and pc-relative target.
`timescale 1ns / 1ps

module rvd_decode
    import rvd_pkg::*;
(
    input  logic [31:0]    instruction,
    input  logic [31:0]    pc,
    output decode_result_t result
);

    // Major opcodes.
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    // funct7 selectors.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MUL  = 7'h01;

    // ALU funct3 codes, shared by register and immediate forms.
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SLT  = 3'b010;
    localparam logic [2:0] F3_SLTU = 3'b011;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SRL  = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;

    // Load and store widths.
    localparam logic [2:0] F3_B  = 3'b000;
    localparam logic [2:0] F3_H  = 3'b001;
    localparam logic [2:0] F3_W  = 3'b010;
    localparam logic [2:0] F3_BU = 3'b100;
    localparam logic [2:0] F3_HU = 3'b101;

    // Branch conditions.
    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_BGE  = 3'b101;
    localparam logic [2:0] F3_BLTU = 3'b110;
    localparam logic [2:0] F3_BGEU = 3'b111;

    // jalr and the system group both need a zero funct3.
    localparam logic [2:0]  F3_ZERO     = 3'b000;
    localparam logic [11:0] SYS_ECALL   = 12'h000;
    localparam logic [11:0] SYS_EBREAK  = 12'h001;

    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [31:0] i_imm;
    logic [31:0] s_imm;
    logic [31:0] b_imm;
    logic [31:0] j_imm;
    logic [31:0] shamt;
    logic [31:0] u_imm;
    logic [5:0]  code;
    logic [31:0] imm_sel;
    logic        pc_rel;
    logic        known;
    logic [31:0] sum;

    // Field slicing and immediate formats.
    assign opcode = instruction[6:0];
    assign rd     = instruction[11:7];
    assign funct3 = instruction[14:12];
    assign rs1    = instruction[19:15];
    assign funct7 = instruction[31:25];
    assign i_imm  = {{20{instruction[31]}}, instruction[31:20]};
    assign s_imm  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign b_imm  = {{19{instruction[31]}}, instruction[31], instruction[7],
                     instruction[30:25], instruction[11:8], 1'b0};
    assign j_imm  = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                     instruction[20], instruction[30:21], 1'b0};
    assign shamt  = {27'd0, instruction[24:20]};
    assign u_imm  = {instruction[31:12], 12'd0};

    // Mnemonic and immediate selection by opcode and function fields.
    always_comb begin
        code    = MN_NONE;
        imm_sel = 32'd0;
        pc_rel  = 1'b0;
        unique case (opcode)
            OP_REG: begin
                if (funct7 == F7_MUL) begin
                    code = MN_MUL + {3'd0, funct3};
                end else if (funct7 == F7_BASE) begin
                    unique case (funct3)
                        F3_ADD:  code = MN_ADD;
                        F3_SLL:  code = MN_SLL;
                        F3_SLT:  code = MN_SLT;
                        F3_SLTU: code = MN_SLTU;
                        F3_XOR:  code = MN_XOR;
                        F3_SRL:  code = MN_SRL;
                        F3_OR:   code = MN_OR;
                        F3_AND:  code = MN_AND;
                        default: code = MN_NONE;
                    endcase
                end else if (funct7 == F7_ALT && funct3 == F3_ADD) begin
                    code = MN_SUB;
                end else if (funct7 == F7_ALT && funct3 == F3_SRL) begin
                    code = MN_SRA;
                end
            end
            OP_IMM: begin
                imm_sel = i_imm;
                unique case (funct3)
                    F3_ADD:  code = MN_ADDI;
                    F3_SLT:  code = MN_SLTI;
                    F3_SLTU: code = MN_SLTIU;
                    F3_XOR:  code = MN_XORI;
                    F3_OR:   code = MN_ORI;
                    F3_AND:  code = MN_ANDI;
                    F3_SLL: begin
                        imm_sel = shamt;
                        if (funct7 == F7_BASE) begin
                            code = MN_SLLI;
                        end
                    end
                    F3_SRL: begin
                        imm_sel = shamt;
                        if (funct7 == F7_ALT) begin
                            code = MN_SRAI;
                        end else if (funct7 == F7_BASE) begin
                            code = MN_SRLI;
                        end
                    end
                    default: code = MN_NONE;
                endcase
            end
            OP_LOAD: begin
                imm_sel = i_imm;
                unique case (funct3)
                    F3_B:    code = MN_LB;
                    F3_H:    code = MN_LH;
                    F3_W:    code = MN_LW;
                    F3_BU:   code = MN_LBU;
                    F3_HU:   code = MN_LHU;
                    default: code = MN_NONE;
                endcase
            end
            OP_STORE: begin
                imm_sel = s_imm;
                unique case (funct3)
                    F3_B:    code = MN_SB;
                    F3_H:    code = MN_SH;
                    F3_W:    code = MN_SW;
                    default: code = MN_NONE;
                endcase
            end
            OP_BRANCH: begin
                imm_sel = b_imm;
                pc_rel  = 1'b1;
                unique case (funct3)
                    F3_BEQ:  code = MN_BEQ;
                    F3_BNE:  code = MN_BNE;
                    F3_BLT:  code = MN_BLT;
                    F3_BGE:  code = MN_BGE;
                    F3_BLTU: code = MN_BLTU;
                    F3_BGEU: code = MN_BGEU;
                    default: code = MN_NONE;
                endcase
            end
            OP_JAL: begin
                code    = MN_JAL;
                imm_sel = j_imm;
                pc_rel  = 1'b1;
            end
            OP_JALR: begin
                imm_sel = i_imm;
                if (funct3 == F3_ZERO) begin
                    code = MN_JALR;
                end
            end
            OP_LUI: begin
                code    = MN_LUI;
                imm_sel = u_imm;
            end
            OP_AUIPC: begin
                code    = MN_AUIPC;
                imm_sel = u_imm;
            end
            OP_SYSTEM: begin
                imm_sel = i_imm;
                if (funct3 == F3_ZERO && rd == 5'd0 && rs1 == 5'd0) begin
                    if (instruction[31:20] == SYS_ECALL) begin
                        code = MN_ECALL;
                    end else if (instruction[31:20] == SYS_EBREAK) begin
                        code = MN_EBREAK;
                    end
                end
            end
            default: code = MN_NONE;
        endcase
    end

    // Target adder; an unrecognized word reports zero immediate and target.
    assign sum   = pc + imm_sel;
    assign known = (code != MN_NONE);

    assign result.recognized = known;
    assign result.code       = code;
    assign result.immediate  = known ? imm_sel : 32'sd0;
    assign result.target     = (known && pc_rel) ? sum : 32'd0;

endmodule

### rtl/core/rvd_checker.sv
// Port-level assertions for the RV32IM instruction decoder, bound to the top level.
`timescale 1ns / 1ps

module rvd_checker
    import rvd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [31:0]        cfg_data,
    input logic               s_valid,
    input logic               s_ready,
    input logic [31:0]        s_instruction,
    input logic               m_valid,
    input logic               m_ready,
    input logic [31:0]        m_item_pc,
    input logic               m_recognized,
    input logic [5:0]         m_mnemonic_code,
    input logic [4:0]         m_dest_reg,
    input logic [4:0]         m_src1_reg,
    input logic [4:0]         m_src2_reg,
    input logic signed [31:0] m_immediate,
    input logic [31:0]        m_target
);

    // The recognized flag agrees with the mnemonic code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_recognized == (m_mnemonic_code != MN_NONE)))
        else $error("recognized flag disagrees with mnemonic code");

    // An unrecognized word carries a zero immediate and target.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_recognized) |-> (m_immediate == 32'sd0 && m_target == 32'd0))
        else $error("unrecognized word with nonzero immediate or target");

    // Only branches and jal carry a target.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_target != 32'd0) |->
            (m_mnemonic_code == MN_BEQ || m_mnemonic_code == MN_BNE ||
             m_mnemonic_code == MN_BLT || m_mnemonic_code == MN_BGE ||
             m_mnemonic_code == MN_BLTU || m_mnemonic_code == MN_BGEU ||
             m_mnemonic_code == MN_JAL))
        else $error("target on an instruction that is not pc-relative");

    // A stalled result holds until its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item_pc) &&
                                   $stable(m_mnemonic_code) && $stable(m_immediate)))
        else $error("stalled result changed before transfer");

endmodule

bind rv32im_instruction_decoder rvd_checker u_rvd_checker (.*);

### tb/tb_rv32im_instruction_decoder.sv
// Self-checking testbench for the RV32IM instruction decoder with a decode scoreboard.
`timescale 1ns / 1ps

module tb_rv32im_instruction_decoder
    import rvd_pkg::*;
;

    // Major opcodes of the supported instruction groups.
    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [9:0][6:0] KNOWN_OPCODES = {
        OPC_SYSTEM, OPC_AUIPC, OPC_LUI, OPC_JALR, OPC_JAL,
        OPC_BRANCH, OPC_STORE, OPC_LOAD, OPC_IMM, OPC_REG
    };

    // Function fields that select between operations.
    localparam logic [6:0] F7_BASE    = 7'h00;
    localparam logic [6:0] F7_ALT     = 7'h20;
    localparam logic [6:0] F7_MULDIV  = 7'h01;
    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SLTU    = 3'd3;
    localparam logic [2:0] F3_SR      = 3'd5;
    localparam logic [2:0] F3_AND     = 3'd7;
    localparam logic [2:0] F3_JALR    = 3'd0;
    localparam logic [2:0] F3_PRIV    = 3'd0;
    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;

    // Mnemonic lookup per funct3, index 7 first.
    localparam logic [7:0][5:0] REG_CODES = {
        MN_AND, MN_OR, MN_SRL, MN_XOR, MN_SLTU, MN_SLT, MN_SLL, MN_ADD
    };
    localparam logic [7:0][5:0] IMM_CODES = {
        MN_ANDI, MN_ORI, MN_NONE, MN_XORI, MN_SLTIU, MN_SLTI, MN_NONE, MN_ADDI
    };
    localparam logic [7:0][5:0] LOAD_CODES = {
        MN_NONE, MN_NONE, MN_LHU, MN_LBU, MN_NONE, MN_LW, MN_LH, MN_LB
    };
    localparam logic [7:0][5:0] STORE_CODES = {
        MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_NONE, MN_SW, MN_SH, MN_SB
    };
    localparam logic [7:0][5:0] BRANCH_CODES = {
        MN_BGEU, MN_BLTU, MN_BGE, MN_BLT, MN_NONE, MN_NONE, MN_BNE, MN_BEQ
    };

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 6;
    localparam int WORDS_PER_PHASE = 285;

    typedef struct packed {
        logic [31:0]        item_pc;
        logic               recognized;
        logic [5:0]         mnemonic_code;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        target;
    } decoded_word_t;

    // Scoreboard: tracks the fetch address and holds decodes still to come out.
    class decode_scoreboard;
        logic [31:0]   start_pc;
        logic [29:0]   word_count;
        decoded_word_t pending_decodes[$];
        int            mismatches;

        function new();
            start_pc = '0;
            word_count = '0;
            mismatches = 0;
        endfunction

        function void restart(logic [31:0] pc);
            start_pc = pc;
            word_count = '0;
        endfunction

        function decoded_word_t decode_word(logic [31:0] w);
            decoded_word_t d;
            logic [6:0]    opc;
            logic [6:0]    f7;
            logic [2:0]    f3;
            logic [31:0]   i_imm;
            logic [31:0]   s_imm;
            logic [31:0]   b_imm;
            logic [31:0]   j_imm;
            logic [31:0]   u_imm;
            logic [31:0]   shamt;
            opc = w[6:0];
            f3 = w[14:12];
            f7 = w[31:25];
            i_imm = {{20{w[31]}}, w[31:20]};
            s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
            b_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            j_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            u_imm = {w[31:12], 12'h000};
            shamt = {27'd0, w[24:20]};

            d.item_pc = start_pc + {word_count, 2'b00};
            d.mnemonic_code = MN_NONE;
            d.immediate = '0;
            d.target = '0;
            d.dest_reg = w[11:7];
            d.src1_reg = w[19:15];
            d.src2_reg = w[24:20];

            case (opc)
                OPC_REG: begin
                    if (f7 == F7_MULDIV)
                        d.mnemonic_code = MN_MUL + {3'b000, f3};
                    else if (f7 == F7_BASE)
                        d.mnemonic_code = REG_CODES[f3];
                    else if (f7 == F7_ALT && f3 == F3_ADD_SUB)
                        d.mnemonic_code = MN_SUB;
                    else if (f7 == F7_ALT && f3 == F3_SR)
                        d.mnemonic_code = MN_SRA;
                end
                OPC_IMM: begin
                    // Shifts carry a 5-bit amount and need an exact funct7.
                    if (f3 == F3_SLL) begin
                        if (f7 == F7_BASE) d.mnemonic_code = MN_SLLI;
                        d.immediate = shamt;
                    end else if (f3 == F3_SR) begin
                        if (f7 == F7_ALT) d.mnemonic_code = MN_SRAI;
                        else if (f7 == F7_BASE) d.mnemonic_code = MN_SRLI;
                        d.immediate = shamt;
                    end else begin
                        d.mnemonic_code = IMM_CODES[f3];
                        d.immediate = i_imm;
                    end
                end
                OPC_LOAD: begin
                    d.mnemonic_code = LOAD_CODES[f3];
                    d.immediate = i_imm;
                end
                OPC_STORE: begin
                    d.mnemonic_code = STORE_CODES[f3];
                    d.immediate = s_imm;
                end
                OPC_BRANCH: begin
                    d.mnemonic_code = BRANCH_CODES[f3];
                    d.immediate = b_imm;
                    d.target = d.item_pc + b_imm;
                end
                OPC_JAL: begin
                    d.mnemonic_code = MN_JAL;
                    d.immediate = j_imm;
                    d.target = d.item_pc + j_imm;
                end
                OPC_JALR: begin
                    if (f3 == F3_JALR) begin
                        d.mnemonic_code = MN_JALR;
                        d.immediate = i_imm;
                    end
                end
                OPC_LUI: begin
                    d.mnemonic_code = MN_LUI;
                    d.immediate = u_imm;
                end
                OPC_AUIPC: begin
                    d.mnemonic_code = MN_AUIPC;
                    d.immediate = u_imm;
                end
                OPC_SYSTEM: begin
                    // Only the exact ecall and ebreak encodings are accepted.
                    if (f3 == F3_PRIV && w[11:7] == 5'd0 && w[19:15] == 5'd0) begin
                        if (w[31:20] == SYS_ECALL) begin
                            d.mnemonic_code = MN_ECALL;
                        end else if (w[31:20] == SYS_EBREAK) begin
                            d.mnemonic_code = MN_EBREAK;
                            d.immediate = 32'sd1;
                        end
                    end
                end
                default: ;
            endcase

            // An unrecognized word reports no immediate and no target.
            if (d.mnemonic_code == MN_NONE) begin
                d.immediate = '0;
                d.target = '0;
            end
            d.recognized = (d.mnemonic_code != MN_NONE);
            return d;
        endfunction

        function void note_input(logic [31:0] w);
            pending_decodes.push_back(decode_word(w));
            word_count = word_count + 30'd1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %h, actual %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(decoded_word_t got);
            decoded_word_t want;
            if (pending_decodes.size() == 0) begin
                $error("result transfer with no decode pending, item_pc %h", got.item_pc);
                mismatches++;
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("item_pc", want.item_pc, got.item_pc);
            compare_field("recognized", {31'd0, want.recognized}, {31'd0, got.recognized});
            compare_field("mnemonic_code", {26'd0, want.mnemonic_code},
                          {26'd0, got.mnemonic_code});
            compare_field("dest_reg", {27'd0, want.dest_reg}, {27'd0, got.dest_reg});
            compare_field("src1_reg", {27'd0, want.src1_reg}, {27'd0, got.src1_reg});
            compare_field("src2_reg", {27'd0, want.src2_reg}, {27'd0, got.src2_reg});
            compare_field("immediate", want.immediate, got.immediate);
            compare_field("target", want.target, got.target);
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [31:0]        s_instruction;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_item_pc;
    logic               m_recognized;
    logic [5:0]         m_mnemonic_code;
    logic [4:0]         m_dest_reg;
    logic [4:0]         m_src1_reg;
    logic [4:0]         m_src2_reg;
    logic signed [31:0] m_immediate;
    logic [31:0]        m_target;

    decode_scoreboard decode_sb;
    decoded_word_t    observed;
    bit               burst_mode;
    int               idle_cycles = 0;

    rv32im_instruction_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instruction   (s_instruction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_pc       (m_item_pc),
        .m_recognized    (m_recognized),
        .m_mnemonic_code (m_mnemonic_code),
        .m_dest_reg      (m_dest_reg),
        .m_src1_reg      (m_src1_reg),
        .m_src2_reg      (m_src2_reg),
        .m_immediate     (m_immediate),
        .m_target        (m_target)
    );

    // Free-running 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    assign observed = {m_item_pc, m_recognized, m_mnemonic_code, m_dest_reg,
                       m_src1_reg, m_src2_reg, m_immediate, m_target};

    // Check every result transfer against the oldest pending decode.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            decode_sb.check_result(observed);
    end

    // Watchdog: abort if no channel completes a transfer for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: outside burst mode, stall a random number of cycles before each transfer.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Present one instruction word after a random gap (none in burst mode) and wait for its transfer.
    task automatic send_word(input logic [31:0] w);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_instruction <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_sb.note_input(w);
    endtask

    // Stop sending and wait until every pending decode has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (decode_sb.pending() != 0) @(posedge aclk);
    endtask

    // Write the start address; the word counter restarts at zero.
    task automatic write_start_pc(input logic [31:0] pc);
        cfg_valid <= 1'b1;
        cfg_data <= pc;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        decode_sb.restart(pc);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed words with random fields, plus some raw noise.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [6:0]  opc;
        w = $urandom();
        if ($urandom_range(0, 99) < 12) return w;
        opc = KNOWN_OPCODES[$urandom_range(0, 9)];
        w[6:0] = opc;
        case (opc)
            OPC_REG: begin
                if ($urandom_range(0, 9) != 0)
                    case ($urandom_range(0, 2))
                        0:       w[31:25] = F7_BASE;
                        1:       w[31:25] = F7_ALT;
                        default: w[31:25] = F7_MULDIV;
                    endcase
            end
            OPC_IMM: begin
                if ((w[14:12] == F3_SLL || w[14:12] == F3_SR) && $urandom_range(0, 9) != 0)
                    w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
            end
            OPC_JALR: begin
                if ($urandom_range(0, 3) != 0) w[14:12] = F3_JALR;
            end
            OPC_SYSTEM: begin
                if ($urandom_range(0, 4) != 0) begin
                    w[19:7] = '0;
                    w[31:20] = $urandom_range(0, 1) ? SYS_EBREAK : SYS_ECALL;
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    // Directed words: field extremes, each instruction group, and the encodings
    // that must be rejected.
    task automatic run_directed();
        logic [31:0] words[$];
        words.push_back(32'h0000_0000);
        words.push_back(32'hFFFF_FFFF);
        words.push_back({F7_BASE, 5'd31, 5'd31, F3_ADD_SUB, 5'd31, OPC_REG});
        words.push_back({F7_ALT, 5'd0, 5'd31, F3_ADD_SUB, 5'd0, OPC_REG});
        words.push_back({F7_ALT, 5'd31, 5'd0, F3_SR, 5'd31, OPC_REG});
        words.push_back({F7_ALT, 5'd1, 5'd2, F3_SLL, 5'd3, OPC_REG});
        words.push_back({F7_MULDIV, 5'd5, 5'd6, F3_SLTU, 5'd7, OPC_REG});
        words.push_back({F7_MULDIV, 5'd31, 5'd31, F3_AND, 5'd31, OPC_REG});
        words.push_back({7'h7F, 5'd1, 5'd1, F3_ADD_SUB, 5'd1, OPC_REG});
        words.push_back({12'h800, 5'd1, F3_ADD_SUB, 5'd2, OPC_IMM});
        words.push_back({12'h7FF, 5'd31, F3_AND, 5'd31, OPC_IMM});
        words.push_back({F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd1, OPC_IMM});
        words.push_back({F7_ALT, 5'd31, 5'd1, F3_SR, 5'd1, OPC_IMM});
        words.push_back({F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd1, OPC_IMM});
        words.push_back({F7_MULDIV, 5'd3, 5'd1, F3_SR, 5'd1, OPC_IMM});
        words.push_back(32'hFFFF_AF83);  // lw x31, -1(x31)
        words.push_back(32'h0000_3003);  // load with a reserved width
        words.push_back(32'hFFFF_AFA3);  // sw with an all-ones offset
        words.push_back(32'h8000_0063);  // beq, most negative offset
        words.push_back(32'hFFFF_FFE3);  // bgeu, every field bit set
        words.push_back(32'h0000_2063);  // branch with a reserved funct3
        words.push_back(32'h7FFF_F06F);  // jal, largest forward offset
        words.push_back(32'h8000_006F);  // jal, most negative offset
        words.push_back(32'h000F_8067);  // jalr x0, 0(x31)
        words.push_back(32'h0000_1067);  // jalr with a nonzero funct3
        words.push_back(32'hFFFF_F0B7);  // lui
        words.push_back(32'h0000_1017);  // auipc
        words.push_back(32'h0000_0073);  // ecall
        words.push_back(32'h0010_0073);  // ebreak
        words.push_back(32'h0000_00F3);  // ecall form with a nonzero rd
        foreach (words[k]) send_word(words[k]);
    endtask

    // Main sequence: reset, directed words, then random phases per start address.
    initial begin
        logic [31:0] phase_pc;
        decode_sb = new();
        burst_mode = 1'b0;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_instruction <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       phase_pc = 32'hFFFF_FFF0;
                1:       phase_pc = 32'hFFFF_FFFF;
                2:       phase_pc = $urandom();
                3:       phase_pc = 32'h0000_0000;
                4:       phase_pc = 32'h7FFF_FFFC;
                default: phase_pc = $urandom();
            endcase
            wait_drained();
            write_start_pc(phase_pc);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                // Back-to-back stretches with no idling on either side.
                burst_mode = (i % 95) < 20;
                send_word(random_word());
            end
        end

        burst_mode = 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        if (decode_sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/core/rvd_pkg.sv
rtl/core/rvd_pc_counter.sv
rtl/core/rvd_decode.sv
rtl/core/rv32im_instruction_decoder.sv
rtl/core/rvd_checker.sv
tb/tb_rv32im_instruction_decoder.sv
